/* rtl/core/mrp_pkg.sv */
// Package with constants and payload types for the max ratio path block.
`default_nettype none
package mrp_pkg;
  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned MaxEdges   = 4096;
  localparam int unsigned FracBits   = 20;
  localparam int unsigned RatioBits  = 34;
  localparam int unsigned NodeW      = 10;
  localparam int unsigned EdgeW      = 12;
  localparam int unsigned CntW       = 13;
  localparam int unsigned ValW       = 64;
  localparam logic [33:0] RatioCap   = 34'd10000 << FracBits;

  typedef struct packed {
    logic [9:0]  edge_source;
    logic [9:0]  edge_target;
    logic [13:0] edge_gain;
    logic [13:0] edge_cost;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic [33:0] best_ratio;
    logic        path_found;
    logic        edges_dropped;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [13:0] gain;
    logic [13:0] cost;
  } edge_t;
endpackage
`default_nettype wire

/* rtl/core/max_ratio_path_dag.sv */
// Top level of the max ratio path search over a loaded edge list.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o   | mrp_pkg::in_item_t
//  out     | output    | out_valid_o/out_stall_i | mrp_pkg::out_item_t
//  cfg     | input     | cfg_we_i            | node_count, 11 bits
//
// Edge loads are accepted back to back, one per cycle, while the block is loading.
// The final edge starts a search that sets up edge lists in memories and runs
// up to 35 longest-path probes. A ratio bit whose candidate lies above the cap
// is skipped without a probe. Reset clears control state at once.
// Input is stalled during the search and while a result waits.
`default_nettype none
module max_ratio_path_dag (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [10:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mrp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mrp_pkg::out_item_t      out_data_o
);
  typedef enum logic [4:0] {
    S_LOAD, S_CLR, S_CNT_RD, S_CNT_WR, S_PFX, S_PFX_WR, S_FILL_RD, S_FILL_WR,
    S_Q0, S_Q0_WR, S_KH, S_KH_E, S_KH_RD, S_KH_WR,
    S_P_INIT, S_P_V, S_P_E, S_P_SRC, S_P_CMP, S_P_END, S_OUT
  } state_e;

  state_e state_q;
  logic [10:0] node_count_q;
  logic [mrp_pkg::CntW-1:0] edge_cnt_q;
  logic ovf_q;

  // Memories.
  mrp_pkg::edge_t edge_mem [mrp_pkg::MaxEdges];
  logic [mrp_pkg::EdgeW-1:0] out_list [mrp_pkg::MaxEdges];
  logic [mrp_pkg::EdgeW-1:0] in_list [mrp_pkg::MaxEdges];
  logic [mrp_pkg::CntW-1:0] ostart [mrp_pkg::MaxNodes];
  logic [mrp_pkg::CntW-1:0] istart [mrp_pkg::MaxNodes];
  logic [mrp_pkg::CntW-1:0] ocnt [mrp_pkg::MaxNodes];
  logic [mrp_pkg::CntW-1:0] icnt [mrp_pkg::MaxNodes];
  logic [mrp_pkg::CntW-1:0] indeg [mrp_pkg::MaxNodes];
  logic [mrp_pkg::NodeW-1:0] topo [mrp_pkg::MaxNodes];
  logic [mrp_pkg::ValW:0] val_mem [mrp_pkg::MaxNodes];

  logic [10:0] n_q;
  logic [mrp_pkg::CntW-1:0] k_q, j_q, jend_q, acc_o_q, acc_i_q;
  logic [10:0] i_q, head_q, tlen_q;
  logic [mrp_pkg::NodeW-1:0] u_q, v_q;
  mrp_pkg::edge_t e_q;
  logic [mrp_pkg::EdgeW-1:0] lst_q;
  logic [mrp_pkg::CntW-1:0] r1_q, r2_q;
  logic [mrp_pkg::CntW-1:0] os_q, is_q;
  logic [mrp_pkg::ValW:0] rv_q, vbest_q;
  logic [mrp_pkg::ValW-1:0] w_q;
  logic [33:0] ratio_q, cand_q;
  logic [5:0] bit_q;
  logic sub_q;
  mrp_pkg::out_item_t res_q;

  logic [47:0] prod;
  logic signed [mrp_pkg::ValW-1:0] cand_val;
  logic used;
  assign prod = 48'(cand_q) * 48'(e_q.cost);
  assign cand_val = $signed(rv_q[mrp_pkg::ValW-1:0]) + $signed(w_q);
  assign used = (11'(e_q.src) < n_q) && (11'(e_q.dst) < n_q);

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  function automatic logic [mrp_pkg::EdgeW-1:0] EdgeIdx(input logic [mrp_pkg::CntW-1:0] a);
    EdgeIdx = a[mrp_pkg::EdgeW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd2;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      edge_cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (edge_cnt_q < mrp_pkg::CntW'(mrp_pkg::MaxEdges)) begin
              edge_cnt_q <= edge_cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_data_i.last_edge) begin
              state_q <= S_CLR;
              i_q <= '0;
              if (node_count_q < 11'd2) n_q <= 11'd2;
              else if (node_count_q > 11'(mrp_pkg::MaxNodes)) n_q <= 11'(mrp_pkg::MaxNodes);
              else n_q <= node_count_q;
            end
          end
        end
        S_CLR: begin
          i_q <= i_q + 1'b1;
          if (i_q == n_q - 1'b1) begin
            state_q <= S_CNT_RD;
            k_q <= '0;
          end
        end
        S_CNT_RD: begin
          if (k_q == edge_cnt_q) begin
            state_q <= S_PFX;
            i_q <= '0;
            acc_o_q <= '0;
            acc_i_q <= '0;
          end else begin
            e_q <= edge_mem[k_q[mrp_pkg::EdgeW-1:0]];
            state_q <= S_CNT_WR;
            sub_q <= 1'b0;
          end
        end
        S_CNT_WR: begin
          // Two read-modify-writes on different count memories.
          if (!sub_q) begin
            r1_q <= ocnt[e_q.src];
            r2_q <= icnt[e_q.dst];
            sub_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_CNT_RD;
          end
        end
        S_PFX: begin
          r1_q <= ocnt[i_q[9:0]];
          r2_q <= icnt[i_q[9:0]];
          state_q <= S_PFX_WR;
        end
        S_PFX_WR: begin
          acc_o_q <= acc_o_q + r1_q;
          acc_i_q <= acc_i_q + r2_q;
          i_q <= i_q + 1'b1;
          if (i_q == n_q - 1'b1) begin
            state_q <= S_FILL_RD;
            k_q <= '0;
          end else begin
            state_q <= S_PFX;
          end
        end
        S_FILL_RD: begin
          if (k_q == edge_cnt_q) begin
            state_q <= S_Q0;
            i_q <= '0;
            tlen_q <= '0;
          end else begin
            e_q <= edge_mem[k_q[mrp_pkg::EdgeW-1:0]];
            state_q <= S_FILL_WR;
            sub_q <= 1'b0;
          end
        end
        S_FILL_WR: begin
          if (!sub_q) begin
            r1_q <= ocnt[e_q.src];
            r2_q <= icnt[e_q.dst];
            os_q <= ostart[e_q.src];
            is_q <= istart[e_q.dst];
            sub_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_FILL_RD;
          end
        end
        S_Q0: begin
          r1_q <= indeg[i_q[9:0]];
          state_q <= S_Q0_WR;
        end
        S_Q0_WR: begin
          if (r1_q == '0) tlen_q <= tlen_q + 1'b1;
          i_q <= i_q + 1'b1;
          if (i_q == n_q - 1'b1) begin
            state_q <= S_KH;
            head_q <= '0;
          end else begin
            state_q <= S_Q0;
          end
        end
        S_KH: begin
          if (head_q == tlen_q) begin
            state_q <= S_P_INIT;
            ratio_q <= '0;
            cand_q <= '0;
            bit_q <= 6'(mrp_pkg::RatioBits);
          end else begin
            u_q <= topo[head_q[9:0]];
            sub_q <= 1'b0;
            state_q <= S_KH_E;
          end
        end
        S_KH_E: begin
          if (!sub_q) begin
            j_q <= ostart[u_q];
            sub_q <= 1'b1;
          end else begin
            jend_q <= ostart[u_q] + ocnt[u_q];
            head_q <= head_q + 1'b1;
            state_q <= S_KH_RD;
            sub_q <= 1'b0;
          end
        end
        S_KH_RD: begin
          if (j_q == jend_q) begin
            state_q <= S_KH;
          end else if (!sub_q) begin
            lst_q <= out_list[j_q[mrp_pkg::EdgeW-1:0]];
            sub_q <= 1'b1;
          end else begin
            e_q <= edge_mem[lst_q];
            sub_q <= 1'b0;
            state_q <= S_KH_WR;
          end
        end
        S_KH_WR: begin
          if (!sub_q) begin
            r1_q <= indeg[e_q.dst];
            sub_q <= 1'b1;
          end else begin
            if (r1_q == mrp_pkg::CntW'(1)) tlen_q <= tlen_q + 1'b1;
            j_q <= j_q + 1'b1;
            sub_q <= 1'b0;
            state_q <= S_KH_RD;
          end
        end
        S_P_INIT: begin
          i_q <= '0;
          state_q <= S_P_V;
        end
        S_P_V: begin
          if (i_q == tlen_q) begin
            state_q <= S_P_END;
            sub_q <= 1'b0;
          end else if (!sub_q) begin
            v_q <= topo[i_q[9:0]];
            sub_q <= 1'b1;
          end else begin
            j_q <= istart[v_q];
            jend_q <= istart[v_q] + icnt[v_q];
            vbest_q <= (v_q == '0) ? {1'b1, {mrp_pkg::ValW{1'b0}}} : '0;
            sub_q <= 1'b0;
            state_q <= S_P_E;
          end
        end
        S_P_E: begin
          if (j_q == jend_q) begin
            i_q <= i_q + 1'b1;
            state_q <= S_P_V;
          end else if (!sub_q) begin
            lst_q <= in_list[j_q[mrp_pkg::EdgeW-1:0]];
            sub_q <= 1'b1;
          end else begin
            e_q <= edge_mem[lst_q];
            sub_q <= 1'b0;
            state_q <= S_P_SRC;
          end
        end
        S_P_SRC: begin
          rv_q <= val_mem[e_q.src];
          w_q <= (mrp_pkg::ValW'(e_q.gain) << mrp_pkg::FracBits) - mrp_pkg::ValW'(prod);
          state_q <= S_P_CMP;
        end
        S_P_CMP: begin
          if (rv_q[mrp_pkg::ValW] && (!vbest_q[mrp_pkg::ValW]
              || cand_val > $signed(vbest_q[mrp_pkg::ValW-1:0]))) begin
            vbest_q <= {1'b1, cand_val};
          end
          j_q <= j_q + 1'b1;
          state_q <= S_P_E;
        end
        S_P_END: begin
          if (!sub_q) begin
            rv_q <= val_mem[10'(n_q - 1'b1)];
            sub_q <= 1'b1;
          end else begin
            sub_q <= 1'b0;
            if (bit_q == 6'(mrp_pkg::RatioBits)) begin
              if (!(rv_q[mrp_pkg::ValW] && !rv_q[mrp_pkg::ValW-1])) begin
                state_q <= S_OUT;
              end
            end else if (rv_q[mrp_pkg::ValW] && !rv_q[mrp_pkg::ValW-1]) begin
              ratio_q <= cand_q;
            end
            if (state_q == S_P_END && !(bit_q == 6'(mrp_pkg::RatioBits)
                && !(rv_q[mrp_pkg::ValW] && !rv_q[mrp_pkg::ValW-1]))) begin
              if (bit_q == '0) begin
                state_q <= S_OUT;
              end else begin
                bit_q <= bit_q - 1'b1;
                state_q <= S_P_INIT;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_LOAD;
            edge_cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: state_q <= S_LOAD;
      endcase
      // Skip candidates above the cap by leaving the ratio untouched.
      if (state_q == S_P_INIT) begin
        if (bit_q == 6'(mrp_pkg::RatioBits)) begin
          cand_q <= '0;
        end else begin
          cand_q <= ratio_q | (34'd1 << bit_q);
          if ((ratio_q | (34'd1 << bit_q)) > mrp_pkg::RatioCap) begin
            if (bit_q != '0) bit_q <= bit_q - 1'b1;
            state_q <= (bit_q == '0) ? S_OUT : S_P_INIT;
          end
        end
      end
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && in_valid_i
        && edge_cnt_q < mrp_pkg::CntW'(mrp_pkg::MaxEdges)) begin
      edge_mem[edge_cnt_q[mrp_pkg::EdgeW-1:0]] <= {in_data_i.edge_source,
        in_data_i.edge_target, in_data_i.edge_gain, in_data_i.edge_cost};
    end
    if (state_q == S_CLR) begin
      ocnt[i_q[9:0]] <= '0;
      icnt[i_q[9:0]] <= '0;
    end
    if (state_q == S_CNT_WR && sub_q && used) begin
      ocnt[e_q.src] <= r1_q + 1'b1;
      icnt[e_q.dst] <= r2_q + 1'b1;
    end
    if (state_q == S_PFX_WR) begin
      ostart[i_q[9:0]] <= acc_o_q;
      istart[i_q[9:0]] <= acc_i_q;
      indeg[i_q[9:0]] <= r2_q;
      ocnt[i_q[9:0]] <= '0;
      icnt[i_q[9:0]] <= '0;
    end
    if (state_q == S_FILL_WR && sub_q && used) begin
      ocnt[e_q.src] <= r1_q + 1'b1;
      icnt[e_q.dst] <= r2_q + 1'b1;
      out_list[EdgeIdx(os_q + r1_q)] <= k_q[mrp_pkg::EdgeW-1:0];
      in_list[EdgeIdx(is_q + r2_q)] <= k_q[mrp_pkg::EdgeW-1:0];
    end
    if (state_q == S_Q0_WR && r1_q == '0) begin
      topo[tlen_q[9:0]] <= i_q[9:0];
    end
    if (state_q == S_KH_WR && sub_q) begin
      indeg[e_q.dst] <= r1_q - 1'b1;
      if (r1_q == mrp_pkg::CntW'(1)) topo[tlen_q[9:0]] <= e_q.dst;
    end
    if (state_q == S_P_INIT) begin
      val_mem[n_q[9:0] - 10'd1] <= '0;
    end
    if (state_q == S_P_E && j_q == jend_q) begin
      val_mem[v_q] <= vbest_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_P_END && sub_q) begin
      res_q.edges_dropped <= ovf_q;
      if (bit_q == 6'(mrp_pkg::RatioBits)) begin
        res_q.path_found <= rv_q[mrp_pkg::ValW] && !rv_q[mrp_pkg::ValW-1];
        res_q.best_ratio <= '0;
      end else if (bit_q == '0) begin
        res_q.best_ratio <= (rv_q[mrp_pkg::ValW] && !rv_q[mrp_pkg::ValW-1])
                            ? cand_q : ratio_q;
      end
    end else if (state_q == S_P_INIT && bit_q != 6'(mrp_pkg::RatioBits)
                 && bit_q == '0
                 && (ratio_q | 34'd1) > mrp_pkg::RatioCap) begin
      res_q.best_ratio <= ratio_q;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/mrp_checker.sv */
// Port checker for the max ratio path block, bound to the top level.
`default_nettype none
module mrp_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire mrp_pkg::out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result waits");
  a_ratio_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.best_ratio <= mrp_pkg::RatioCap)
    else $error("ratio above cap");
  a_nopath: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.path_found |-> out_data_o.best_ratio == '0)
    else $error("ratio without path");
endmodule

bind max_ratio_path_dag mrp_checker u_mrp_checker (.*);
`default_nettype wire

/* tb/max_ratio_path_dag_checker.sv */
// Checker that predicts and compares the ratio results of the max ratio path block.
module max_ratio_path_dag_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [10:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire mrp_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire mrp_pkg::out_item_t out_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  mrp_pkg::edge_t     graph_edges[mrp_pkg::MaxEdges];
  int                 graph_size;
  bit                 graph_overflow;
  logic [10:0]        node_reg;
  mrp_pkg::out_item_t ratio_queue[$];
  int                 indeg[mrp_pkg::MaxNodes];
  int                 order[mrp_pkg::MaxNodes];
  int                 order_len;
  bit                 reach[mrp_pkg::MaxNodes];
  longint             path_val[mrp_pkg::MaxNodes];

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic bit edge_live(int k, int n);
    return graph_edges[k].src < n && graph_edges[k].dst < n;
  endfunction

  function automatic void sort_nodes(int n);
    int head;
    int u;
    order_len = 0;
    for (int i = 0; i < n; i++) indeg[i] = 0;
    for (int k = 0; k < graph_size; k++)
      if (edge_live(k, n)) indeg[graph_edges[k].dst]++;
    for (int i = 0; i < n; i++)
      if (indeg[i] == 0) order[order_len++] = i;
    head = 0;
    while (head < order_len) begin
      u = order[head++];
      for (int k = 0; k < graph_size; k++)
        if (edge_live(k, n) && graph_edges[k].src == u) begin
          indeg[graph_edges[k].dst]--;
          if (indeg[graph_edges[k].dst] == 0) order[order_len++] = graph_edges[k].dst;
        end
    end
  endfunction

  function automatic bit ratio_feasible(longint unsigned ratio, int n);
    int v;
    int s;
    longint w;
    longint cand;
    for (int i = 0; i < n; i++) reach[i] = 0;
    reach[0] = 1;
    path_val[0] = 0;
    for (int i = 0; i < order_len; i++) begin
      v = order[i];
      for (int k = 0; k < graph_size; k++) begin
        if (!edge_live(k, n) || graph_edges[k].dst != v) continue;
        s = graph_edges[k].src;
        if (!reach[s]) continue;
        w = longint'({30'd0, graph_edges[k].gain} << mrp_pkg::FracBits)
            - longint'(ratio * longint'(graph_edges[k].cost));
        cand = path_val[s] + w;
        if (!reach[v] || cand > path_val[v]) begin
          reach[v] = 1;
          path_val[v] = cand;
        end
      end
    end
    return reach[n - 1] && path_val[n - 1] >= 0;
  endfunction

  function automatic mrp_pkg::out_item_t search_best_ratio();
    mrp_pkg::out_item_t r;
    int n;
    longint unsigned ratio;
    longint unsigned cand;
    n = node_reg < 2 ? 2 : (node_reg > mrp_pkg::MaxNodes ? mrp_pkg::MaxNodes
                                                          : int'(node_reg));
    sort_nodes(n);
    ratio = 0;
    r.path_found = ratio_feasible(0, n);
    if (r.path_found)
      for (int b = mrp_pkg::RatioBits - 1; b >= 0; b--) begin
        cand = ratio | (64'd1 << b);
        if (cand > {30'd0, mrp_pkg::RatioCap}) continue;
        if (ratio_feasible(cand, n)) ratio = cand;
      end
    r.best_ratio = ratio[33:0];
    r.edges_dropped = graph_overflow;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mrp_pkg::out_item_t got;
    mrp_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      graph_size = 0;
      graph_overflow = 0;
      node_reg = 11'd2;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) node_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (graph_size < mrp_pkg::MaxEdges) begin
          graph_edges[graph_size] = '{in_data_i.edge_source, in_data_i.edge_target,
                                      in_data_i.edge_gain, in_data_i.edge_cost};
          graph_size = graph_size + 1;
        end else graph_overflow = 1;
        if (in_data_i.last_edge) begin
          ratio_queue = {ratio_queue, search_best_ratio()};
          graph_size = 0;
          graph_overflow = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (ratio_queue.size() == 0) report_mismatch("result with none expected");
        else begin
          exp_r = ratio_queue.pop_front();
          if (got.best_ratio !== exp_r.best_ratio)
            report_mismatch($sformatf("best_ratio %0h expected %0h",
                                      got.best_ratio, exp_r.best_ratio));
          if (got.path_found !== exp_r.path_found)
            report_mismatch($sformatf("path_found %0b expected %0b",
                                      got.path_found, exp_r.path_found));
          if (got.edges_dropped !== exp_r.edges_dropped)
            report_mismatch($sformatf("edges_dropped %0b expected %0b",
                                      got.edges_dropped, exp_r.edges_dropped));
        end
      end
      pending_o = ratio_queue.size();
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top that drives edge lists into the max ratio path block and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [10:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  mrp_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mrp_pkg::out_item_t out_data_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  longint             cycle_count;
  int                 graph_nodes;

  max_ratio_path_dag dut (.*);

  max_ratio_path_dag_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_stall_i(in_stall_o), .in_data_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_data_i(out_data_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 10000000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  task automatic send_edge(input int s, input int t, input int g, input int c,
                           input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{s[9:0], t[9:0], g[13:0], c[13:0], last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_nodes(input int n);
    cfg_we_i <= 1;
    cfg_wdata_i <= n[10:0];
    graph_nodes = n;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_random_graph(input int edges);
    int n;
    int s;
    int t;
    n = graph_nodes < 2 ? 2 : (graph_nodes > 1024 ? 1024 : graph_nodes);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(1023);
        t = $urandom_range(1023);
      end else begin
        s = $urandom_range(n - 1);
        t = $urandom_range(n - 1);
        if ($urandom_range(3) != 0 && s > t) begin
          s = s ^ t; t = s ^ t; s = s ^ t;
        end
        if ($urandom_range(7) == 0) s = 0;
        if ($urandom_range(7) == 0) t = n - 1;
      end
      send_edge(s, t, $urandom_range(16383), $urandom_range(16383), i == edges - 1);
    end
  endtask

  initial begin
    int sizes[6];
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    in_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    graph_nodes = 2;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_edge(0, 1, 10000, 1, 1);
    drain_and_idle();
    send_edge(0, 1, 16383, 16383, 0);
    send_edge(0, 1, 0, 0, 0);
    send_edge(1, 0, 1, 10000, 1);
    drain_and_idle();
    send_edge(1023, 1023, 16383, 16383, 1);
    drain_and_idle();
    set_nodes(0);
    send_edge(0, 1, 5, 3, 1);
    drain_and_idle();
    set_nodes(4);
    send_edge(0, 1, 7, 2, 0);
    send_edge(1, 3, 9, 4, 0);
    send_edge(0, 2, 100, 1, 0);
    send_edge(2, 2, 1, 1, 0);
    send_edge(2, 3, 1, 1, 0);
    send_edge(0, 3, 3, 9, 1);
    drain_and_idle();
    send_edge(0, 1, 4, 4, 1);
    drain_and_idle();
    set_nodes(2047);
    send_edge(0, 1023, 682, 5461, 1);
    drain_and_idle();
    set_nodes(1024);
    send_edge(0, 1023, 16383, 1, 1);
    drain_and_idle();

    sizes = '{2, 3, 8, 20, 64, 1024};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 10) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 10) : 0;
      for (int gph = 0; gph < 14; gph++) begin
        set_nodes(sizes[(gph == 13) ? 5 : $urandom_range(4)]);
        send_random_graph(graph_nodes > 64 ? 20 : $urandom_range(1, 38));
        drain_and_idle();
      end
    end

    in_valid_i <= 0;
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
